// ===== rtl/msl_pkg.sv =====
// ----------------------------------------------------------------------------
// msl_pkg
// Shared constants for the multi-row substring locator.
// ----------------------------------------------------------------------------
package msl_pkg;

  localparam int KeyMax   = 32;
  localparam int WinLen   = KeyMax - 1;
  localparam int CntBits  = 16;
  localparam int CharW    = 8;
  localparam int LenW     = 6;
  localparam int CfgW     = 64;
  localparam int CfgIdxW  = 3;
  localparam int OutW     = 16;
  localparam int LenIdxW  = $clog2(KeyMax);
  localparam int BytesPerReg = CfgW / CharW;

  localparam logic [CntBits-1:0] CntMax = {CntBits{1'b1}};

  localparam logic [CfgIdxW-1:0] CfgKeyLen    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyChars0 = 3'd1;

  localparam logic ResMatch   = 1'b0;
  localparam logic ResSummary = 1'b1;

endpackage

// ===== rtl/multi_row_substring_locator.sv =====
// ----------------------------------------------------------------------------
// multi_row_substring_locator
// Streaming search for all occurrences of a configured key over rows of text.
// ----------------------------------------------------------------------------
// Timing: a result is registered and is valid in the cycle after the item that causes it.
// Throughput: one item per cycle; the single-stage window compare and the
// output register set that figure. An item waits only while a result is held
// by a stalled receiver.
// Reset: counters, window characters and the result valid flag clear; the key
// length returns to one and the key characters to zero.
module multi_row_substring_locator
  import msl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CharW-1:0]   text_char_i,
  input  logic               row_end_i,
  input  logic               set_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic [OutW-1:0]    match_row_o,
  output logic [OutW-1:0]    match_col_o,
  output logic [OutW-1:0]    total_matches_o
);

  logic [LenW-1:0]             len_q;
  logic [KeyMax-1:0][CharW-1:0] key_q;

  logic [CntBits-1:0] col_q, col_d;
  logic [CntBits-1:0] row_q, row_d;
  logic [CntBits-1:0] total_q, total_d;

  logic               out_valid_q, out_valid_d;
  logic               kind_q;
  logic [CntBits-1:0] res_row_q, res_col_q, res_total_q;

  logic               in_acc;
  logic               is_char;
  logic               hit;
  logic               len_ok;
  logic               cur_eq;
  logic [CntBits-1:0] col_inc;
  logic               adv;
  logic [WinLen-1:0][CharW-1:0] win;
  logic [WinLen-1:0][CharW-1:0] key_align;
  logic [WinLen-1:0]  eq_vec;
  logic [WinLen-1:0]  need_vec;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
    end else if (cfg_we_i && cfg_idx_i == CfgKeyLen) begin
      len_q <= cfg_wdata_i[LenW-1:0];
    end
  end

  for (genvar j = 0; j < KeyMax; j++) begin : g_key
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        key_q[j] <= '0;
      end else if (cfg_we_i &&
                   cfg_idx_i == CfgIdxW'(int'(CfgKeyChars0) + j / BytesPerReg)) begin
        key_q[j] <= cfg_wdata_i[(j % BytesPerReg) * CharW +: CharW];
      end
    end
  end

  // Handshake and window control
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_char    = !row_end_i && !set_end_i;
  assign adv        = in_acc && is_char;

  for (genvar k = 0; k < WinLen; k++) begin : g_cell
    logic [CharW-1:0] char_in;
    if (k == 0) begin : g_first
      assign char_in = text_char_i;
    end else begin : g_next
      assign char_in = win[k-1];
    end
    assign need_vec[k]  = (len_q > LenW'(k + 1));
    assign key_align[k] = key_q[LenIdxW'(len_q - LenW'(k + 2))];
    msl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .char_i     (char_in),
      .key_byte_i (key_align[k]),
      .char_o     (win[k]),
      .eq_o       (eq_vec[k])
    );
  end

  assign len_ok  = (len_q != '0) && (int'(len_q) <= KeyMax);
  assign cur_eq  = (text_char_i == key_q[LenIdxW'(len_q - LenW'(1))]);
  assign col_inc = (col_q == CntMax) ? CntMax : col_q + CntBits'(1);
  assign hit     = len_ok && (col_inc >= CntBits'(len_q)) && cur_eq &&
                   (&(eq_vec | ~need_vec));

  // Counters
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    total_d = total_q;
    if (in_acc) begin
      priority if (set_end_i) begin
        col_d   = '0;
        row_d   = '0;
        total_d = '0;
      end else if (row_end_i) begin
        col_d = '0;
        row_d = (row_q == CntMax) ? CntMax : row_q + CntBits'(1);
      end else begin
        col_d = col_inc;
        if (hit) begin
          total_d = (total_q == CntMax) ? CntMax : total_q + CntBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      total_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      total_q <= total_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = set_end_i || (is_char && hit);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && set_end_i) begin
      kind_q      <= ResSummary;
      res_row_q   <= '0;
      res_col_q   <= '0;
      res_total_q <= total_q;
    end else if (in_acc && is_char && hit) begin
      kind_q      <= ResMatch;
      res_row_q   <= row_q;
      res_col_q   <= col_inc - CntBits'(len_q);
      res_total_q <= total_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign match_row_o     = OutW'(res_row_q);
  assign match_col_o     = OutW'(res_col_q);
  assign total_matches_o = OutW'(res_total_q);

  a_summary_zero_loc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == ResSummary |-> match_row_o == '0 && match_col_o == '0)
    else $error("summary carries a nonzero location");

  a_set_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && set_end_i |=> row_q == '0 && col_q == '0 && total_q == '0)
    else $error("counters not cleared at set end");

  a_window_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> win[0] == $past(text_char_i))
    else $error("window did not take the accepted character");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

endmodule

// ===== rtl/msl_cell.sv =====
// ----------------------------------------------------------------------------
// msl_cell
// One window position: holds a recent character, hands it to its neighbor on
// each advance and compares it with the key character aligned to it.
// ----------------------------------------------------------------------------
module msl_cell
  import msl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [CharW-1:0] char_i,
  input  logic [CharW-1:0] key_byte_i,
  output logic [CharW-1:0] char_o,
  output logic             eq_o
);

  logic [CharW-1:0] char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else if (adv_i) begin
      char_q <= char_i;
    end
  end

  assign char_o = char_q;
  assign eq_o   = (char_q == key_byte_i);

endmodule
